// ===== src/sfr_pkg.sv =====
// Package for the streaming find-and-replace block.
// Holds the cell control type and the ASCII case-folding function.
// Used by sfr_cell and stream_find_replace_all_top.
package sfr_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam int REPLACE_MAX_DEF = 32;
	localparam int CAPACITY_MAX_DEF = 4096;

	typedef enum logic [1:0] {
		OP_TEXT = 2'd0,
		OP_EOL  = 2'd1,
		OP_PAT  = 2'd2,
		OP_REP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_IGNORE_CASE = 2'd0,
		REG_PAT_LEN     = 2'd1,
		REG_REP_LEN     = 2'd2,
		REG_LINE_CAP    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic shift;
		logic ignore_case;
	} sfr_ctl_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
		logic [7:0] r;
		r = c;
		if (ic && c >= 8'h41 && c <= 8'h5a) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

endpackage

// ===== src/sfr_cell.sv =====
// One position of the pending window: a held text byte and its pattern byte.
// Shifts toward the front from its neighbor; depends on sfr_pkg.
module sfr_cell
	import sfr_pkg::*;
(
	input  logic       clk,
	input  sfr_ctl_t   ctl,
	input  logic       wr,
	input  logic       pwr,
	input  logic [7:0] din,
	input  logic [7:0] nxt,
	output logic [7:0] win,
	output logic       hit
);

	logic [7:0] win_q;
	logic [7:0] pat_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			win_q <= din;
		end else if (ctl.shift) begin
			win_q <= nxt;
		end
		if (pwr) begin
			pat_q <= din;
		end
	end

	assign win = win_q;
	assign hit = fold(win_q, ctl.ignore_case) == fold(pat_q, ctl.ignore_case);

endmodule

// ===== src/stream_find_replace_all_top.sv =====
// Top level of the streaming find-and-replace block: control sequencer,
// replacement store, line counters and output register over a chain of sfr_cell.
// Depends on sfr_pkg and sfr_cell.
//
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    operation, value, index
// out      source     out_valid / out_ready  out_char, has_char, end_of_line,
//                                            line_changed, truncated
// cfg      sink       cfg_we                 cfg_index, cfg_data
//
// A text byte is appended after the front byte is released if the window is full; bytes
// are then released until the window holds the pattern or a prefix, and a full match is
// replaced. An end of line flushes pending bytes, then a marker. The one-byte output
// register sets the pace: every emitted byte waits for a free slot. Reset clears
// counters and flags; pattern, replacement and window bytes are undefined until written.
module stream_find_replace_all_top
	import sfr_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int REPLACE_MAX = REPLACE_MAX_DEF,
	parameter int CAPACITY_MAX = CAPACITY_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  value,
	input  logic [4:0]  index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        has_char,
	output logic        end_of_line,
	output logic        line_changed,
	output logic        truncated,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int CNTW = $clog2(PATTERN_MAX + 1);
	localparam int RCW = $clog2(REPLACE_MAX + 1);
	localparam int RIW = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
	localparam int CW = $clog2(CAPACITY_MAX + 1);
	localparam int LW = (CW > 13) ? CW : 13;
	localparam int OCW = $clog2(CAPACITY_MAX);

	typedef enum logic [2:0] {S_IDLE, S_PRE, S_EVAL, S_REPL, S_FLUSH} state_t;

	state_t st_q, st_d;

	logic              ic_q;
	logic [5:0]        plen_q;
	logic [5:0]        rlen_q;
	logic [12:0]       cap_q;
	logic [CNTW-1:0]   cnt_q;
	logic [OCW-1:0]    ocnt_q;
	logic              chg_q;
	logic              trn_q;
	logic [7:0]        val_q;
	logic [RCW-1:0]    ri_q;
	logic [7:0]        rep_q [REPLACE_MAX];
	logic              ov_q;
	logic [7:0]        oc_q;
	logic              oh_q;
	logic              oe_q;
	logic              ochg_q;
	logic              otrn_q;

	logic [CNTW-1:0]   plen;
	logic [RCW-1:0]    rlen;
	logic [LW-1:0]     cap_e;
	logic [LW-1:0]     lim;
	logic              under;
	logic              can_emit;

	sfr_ctl_t          ctl;
	logic [7:0]        win [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] hit;
	logic [PATTERN_MAX-1:0] wr;
	logic [PATTERN_MAX-1:0] pwr;
	logic [PATTERN_MAX-1:0] m_cnt;
	logic [PATTERN_MAX-1:0] m_pl;
	logic              ok_cnt;
	logic              ok_pl;
	logic [7:0]        cell_din;

	logic              rel;
	logic              app;
	logic              em_byte;
	logic              em_mark;
	logic [7:0]        em_ch;
	logic              stall;
	logic              push;
	logic              go_repl;
	logic              ld_txt;

	always_comb begin
		if (plen_q == 6'd0) begin
			plen = CNTW'(1);
		end else if (plen_q > 6'(PATTERN_MAX)) begin
			plen = CNTW'(PATTERN_MAX);
		end else begin
			plen = plen_q[CNTW-1:0];
		end
		if (rlen_q > 6'(REPLACE_MAX)) begin
			rlen = RCW'(REPLACE_MAX);
		end else begin
			rlen = rlen_q[RCW-1:0];
		end
		if (LW'(cap_q) < LW'(2)) begin
			cap_e = LW'(2);
		end else if (LW'(cap_q) > LW'(CAPACITY_MAX)) begin
			cap_e = LW'(CAPACITY_MAX);
		end else begin
			cap_e = LW'(cap_q);
		end
	end

	assign lim = cap_e - LW'(1);
	assign under = LW'(ocnt_q) < lim;
	assign can_emit = !ov_q || out_ready;

	assign ctl.shift = rel && !stall;
	assign ctl.ignore_case = ic_q;
	assign cell_din = (st_q == S_IDLE) ? value : val_q;

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			m_cnt[i] = hit[i] || !(CNTW'(i) < cnt_q);
			m_pl[i] = hit[i] || !(CNTW'(i) < plen);
			wr[i] = app && (cnt_q == CNTW'(i));
			pwr[i] = in_valid && in_ready && (operation == OP_PAT)
				&& (index == 5'(i));
		end
	end

	assign ok_cnt = &m_cnt;
	assign ok_pl = &m_pl;

	genvar g;
	generate
		for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
			sfr_cell u_cell (
				.clk (clk),
				.ctl (ctl),
				.wr  (wr[g]),
				.pwr (pwr[g]),
				.din (cell_din),
				.nxt ((g == PATTERN_MAX - 1) ? 8'd0 : win[(g + 1) % PATTERN_MAX]),
				.win (win[g]),
				.hit (hit[g])
			);
		end
	endgenerate

	always_comb begin
		st_d = st_q;
		rel = 1'b0;
		app = 1'b0;
		em_byte = 1'b0;
		em_mark = 1'b0;
		em_ch = win[0];
		go_repl = 1'b0;
		ld_txt = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					case (operation)
						OP_TEXT: begin
							ld_txt = 1'b1;
							st_d = S_PRE;
						end
						OP_EOL: st_d = S_FLUSH;
						default: st_d = S_IDLE;
					endcase
				end
			end
			S_PRE: begin
				if (cnt_q == CNTW'(PATTERN_MAX)) begin
					rel = 1'b1;
					em_byte = 1'b1;
				end else begin
					app = 1'b1;
					st_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (cnt_q == '0) begin
					st_d = S_IDLE;
				end else if (cnt_q == plen && ok_pl) begin
					go_repl = 1'b1;
					st_d = S_REPL;
				end else if (cnt_q < plen && ok_cnt) begin
					st_d = S_IDLE;
				end else begin
					rel = 1'b1;
					em_byte = 1'b1;
				end
			end
			S_REPL: begin
				if (ri_q == rlen) begin
					st_d = S_IDLE;
				end else begin
					em_byte = 1'b1;
					em_ch = rep_q[ri_q[RIW-1:0]];
				end
			end
			S_FLUSH: begin
				if (cnt_q != '0) begin
					rel = 1'b1;
					em_byte = 1'b1;
				end else begin
					em_mark = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	assign stall = ((em_byte && under) || em_mark) && !can_emit;
	assign push = ((em_byte && under) || em_mark) && can_emit;
	assign in_ready = (st_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && operation == OP_REP && 32'(index) < REPLACE_MAX) begin
			rep_q[index[RIW-1:0]] <= value;
		end
		if (ld_txt) begin
			val_q <= value;
		end
		if (push) begin
			oc_q <= em_mark ? 8'd0 : em_ch;
			oh_q <= !em_mark;
			oe_q <= em_mark;
			ochg_q <= em_mark && chg_q;
			otrn_q <= em_mark && trn_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ic_q <= 1'b0;
			plen_q <= 6'd1;
			rlen_q <= 6'd0;
			cap_q <= 13'd1024;
			cnt_q <= '0;
			ocnt_q <= '0;
			chg_q <= 1'b0;
			trn_q <= 1'b0;
			ri_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IGNORE_CASE: ic_q <= cfg_data[0];
					REG_PAT_LEN: plen_q <= cfg_data[5:0];
					REG_REP_LEN: rlen_q <= cfg_data[5:0];
					REG_LINE_CAP: cap_q <= cfg_data;
					default: ;
				endcase
			end
			if (push) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (!stall) begin
				st_q <= st_d;
				if (em_byte && !under) begin
					trn_q <= 1'b1;
				end
				if (em_byte && under) begin
					ocnt_q <= ocnt_q + OCW'(1);
				end
				if (rel) begin
					cnt_q <= cnt_q - CNTW'(1);
				end
				if (app) begin
					cnt_q <= cnt_q + CNTW'(1);
				end
				if (go_repl) begin
					cnt_q <= '0;
					chg_q <= 1'b1;
					ri_q <= '0;
				end
				if (st_q == S_REPL && em_byte) begin
					ri_q <= ri_q + RCW'(1);
				end
				if (em_mark) begin
					ocnt_q <= '0;
					chg_q <= 1'b0;
					trn_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid = ov_q;
	assign out_char = oc_q;
	assign has_char = oh_q;
	assign end_of_line = oe_q;
	assign line_changed = ochg_q;
	assign truncated = otrn_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(PATTERN_MAX))
		else $error("pending count above window depth");

	a_mark_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(push && em_mark) |-> (cnt_q == '0))
		else $error("end marker sent with pending bytes");

	a_mark_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(push && em_mark) |=> (!chg_q && !trn_q && ocnt_q == '0))
		else $error("line state not cleared after end marker");

	a_out_cap: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(ocnt_q) <= lim)
		else $error("output count beyond line capacity");
`endif

endmodule
